[hdl/cdow_pkg.sv]
package cdow_pkg;

  localparam int unsigned YEAR_MIN     = 1;
  localparam int unsigned YEAR_MAX     = 9999;
  localparam int unsigned DIV100_MUL   = 5243;
  localparam int unsigned DIV100_SHIFT = 19;

  localparam logic       REQ_ADD = 1'b0;
  localparam logic       REQ_SUB = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [4:0]  start_day;
    logic [3:0]  start_month;
    logic [13:0] start_year;
    logic [7:0]  day_count;
  } req_t;

  typedef struct packed {
    logic [4:0]  result_day;
    logic [3:0]  result_month;
    logic [13:0] result_year;
    logic [2:0]  weekday;
    logic        year_out_of_range;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_REMAIN,
    ST_CLAMP,
    ST_STEP,
    ST_FIX,
    ST_WEEK,
    ST_REDUCE
  } state_t;

  function automatic logic cdow_leap(input logic [6:0] cent, input logic [6:0] yy);
    logic leap;
    leap = ((yy[1:0] == 2'd0) && (yy != 7'd0)) || ((yy == 7'd0) && (cent[1:0] == 2'd0));
    return leap;
  endfunction

  function automatic logic [4:0] cdow_month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    unique case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // floor(13 * (m + 1) / 5), January and February counted as months 13 and 14
  function automatic logic [5:0] cdow_month_term(input logic [3:0] month);
    logic [5:0] term;
    unique case (month)
      4'd1:    term = 6'd36;
      4'd2:    term = 6'd39;
      4'd3:    term = 6'd10;
      4'd4:    term = 6'd13;
      4'd5:    term = 6'd15;
      4'd6:    term = 6'd18;
      4'd7:    term = 6'd20;
      4'd8:    term = 6'd23;
      4'd9:    term = 6'd26;
      4'd10:   term = 6'd28;
      4'd11:   term = 6'd31;
      default: term = 6'd33;
    endcase
    return term;
  endfunction

  function automatic logic [2:0] cdow_mod7(input logic [9:0] x);
    logic [4:0] s1;
    logic [3:0] s2;
    logic [3:0] r;
    s1 = 5'({2'b0, x[2:0]}) + 5'({2'b0, x[5:3]}) + 5'({2'b0, x[8:6]}) + 5'({4'b0, x[9]});
    s2 = 4'({1'b0, s1[2:0]}) + 4'({2'b0, s1[4:3]});
    r  = (s2 >= 4'd7) ? (s2 - 4'd7) : s2;
    return r[2:0];
  endfunction

endpackage

[hdl/calendar_date_offset_weekday_top.sv]
// Gregorian date offset with weekday.
// Request channel: drive req and raise start; the request is taken at a clock
// edge where start is high and busy is low. busy stays high until the result
// is out. Result channel: done pulses for one cycle with rsp valid in that
// cycle; the receiver must take it then, there is no back-pressure.
// The shared subtractor takes one month step a cycle; the year is split into
// century and year-of-century by a reciprocal multiply (ST_DIVIDE) and a
// remainder subtraction (ST_REMAIN), and the weekday sum and its reduction
// modulo 7 are done in separate states, ST_WEEK and ST_REDUCE. A new
// request may start in the cycle done is high.
// Out-of-range input fields are pulled into range; a year outside 1..9999,
// before or after the step, clamps the date and sets year_out_of_range.
// Reset (rst, synchronous, active high) returns the sequencer to idle and
// clears done; a request in progress is dropped.
module calendar_date_offset_weekday_top
  import cdow_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic done,
  output rsp_t rsp
);

  state_t      state, state_next;
  logic        sub, sub_next;
  logic [8:0]  day, day_next;
  logic [3:0]  month, month_next;
  logic [13:0] year, year_next;
  logic [6:0]  cent, cent_next;
  logic [6:0]  yy, yy_next;
  logic [7:0]  count, count_next;
  logic        flag, flag_next;
  logic [9:0]  wsum, wsum_next;
  logic        done_next;
  rsp_t        rsp_reg, rsp_next;

  logic [8:0]  op_a, op_b;
  logic [9:0]  diff;

  logic        cur_leap;
  logic [4:0]  cur_len;
  logic [3:0]  dec_month;
  logic [13:0] dec_year;
  logic [6:0]  dec_cent, dec_yy;
  logic [4:0]  dec_len;
  logic [26:0] prod;
  logic [13:0] cent_x100;
  logic [6:0]  zk, zj;
  logic [3:0]  in_month;
  logic [13:0] in_year;

  assign diff = {1'b0, op_a} - {1'b0, op_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    sub     <= sub_next;
    day     <= day_next;
    month   <= month_next;
    year    <= year_next;
    cent    <= cent_next;
    yy      <= yy_next;
    count   <= count_next;
    flag    <= flag_next;
    wsum    <= wsum_next;
    rsp_reg <= rsp_next;
  end

  always_comb begin
    state_next = state;
    sub_next   = sub;
    day_next   = day;
    month_next = month;
    year_next  = year;
    cent_next  = cent;
    yy_next    = yy;
    count_next = count;
    flag_next  = flag;
    wsum_next  = wsum;
    rsp_next   = rsp_reg;
    done_next  = 1'b0;
    op_a       = day;
    op_b       = 9'd0;

    cur_leap  = cdow_leap(cent, yy);
    cur_len   = cdow_month_len(month, cur_leap);
    dec_month = (month == 4'd1) ? 4'd12 : (month - 4'd1);
    dec_year  = (month == 4'd1) ? (year - 14'd1) : year;
    dec_yy    = yy;
    dec_cent  = cent;
    if (month == 4'd1) begin
      dec_yy   = (yy == 7'd0) ? 7'd99 : (yy - 7'd1);
      dec_cent = (yy == 7'd0) ? (cent - 7'd1) : cent;
    end
    dec_len   = cdow_month_len(dec_month, cdow_leap(dec_cent, dec_yy));
    prod      = 27'(year) * 27'(DIV100_MUL);
    cent_x100 = 14'({7'd0, cent} * 14'd100);

    zk = yy;
    zj = cent;
    if (month < 4'd3) begin
      zk = (yy == 7'd0) ? 7'd99 : (yy - 7'd1);
      zj = (yy == 7'd0) ? (cent - 7'd1) : cent;
    end

    in_month = req.start_month;
    if (in_month == 4'd0) in_month = 4'd1;
    if (in_month > 4'd12) in_month = 4'd12;
    in_year = req.start_year;
    if (in_year < 14'(YEAR_MIN)) in_year = 14'(YEAR_MIN);
    if (in_year > 14'(YEAR_MAX)) in_year = 14'(YEAR_MAX);

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          sub_next   = req.req_type;
          day_next   = (req.start_day == 5'd0) ? 9'd1 : {4'd0, req.start_day};
          month_next = in_month;
          year_next  = in_year;
          count_next = req.day_count;
          flag_next  = (req.start_year < 14'(YEAR_MIN)) || (req.start_year > 14'(YEAR_MAX));
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cent_next  = prod[DIV100_SHIFT +: 7];
        state_next = ST_REMAIN;
      end
      ST_REMAIN: begin
        yy_next    = 7'(year - cent_x100);
        state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        if (day > {4'd0, cur_len}) day_next = {4'd0, cur_len};
        if (sub == REQ_ADD) begin
          day_next   = ((day > {4'd0, cur_len}) ? {4'd0, cur_len} : day) + {1'b0, count};
          count_next = 8'd0;
        end
        state_next = ST_STEP;
      end
      ST_STEP: begin
        if (sub == REQ_ADD) begin
          op_a = day;
          op_b = {4'd0, cur_len};
          if (diff[9] || (diff == 10'd0)) begin
            state_next = ST_FIX;
          end else begin
            day_next = diff[8:0];
            if (month == 4'd12) begin
              month_next = 4'd1;
              year_next  = year + 14'd1;
              yy_next    = (yy == 7'd99) ? 7'd0 : (yy + 7'd1);
              cent_next  = (yy == 7'd99) ? (cent + 7'd1) : cent;
            end else begin
              month_next = month + 4'd1;
            end
          end
        end else begin
          op_a = {1'b0, count};
          op_b = day;
          if (diff[9]) begin
            state_next = ST_FIX;
          end else begin
            count_next = diff[7:0];
            month_next = dec_month;
            year_next  = dec_year;
            yy_next    = dec_yy;
            cent_next  = dec_cent;
            day_next   = {4'd0, dec_len};
          end
        end
      end
      ST_FIX: begin
        op_a     = day;
        op_b     = {1'b0, count};
        day_next = diff[8:0];
        if (year > 14'(YEAR_MAX)) begin
          year_next  = 14'(YEAR_MAX);
          month_next = 4'd12;
          day_next   = 9'd31;
          cent_next  = 7'd99;
          yy_next    = 7'd99;
          flag_next  = 1'b1;
        end else if (year < 14'(YEAR_MIN)) begin
          year_next  = 14'(YEAR_MIN);
          month_next = 4'd1;
          day_next   = 9'd1;
          cent_next  = 7'd0;
          yy_next    = 7'd1;
          flag_next  = 1'b1;
        end
        state_next = ST_WEEK;
      end
      ST_WEEK: begin
        wsum_next = 10'({5'd0, day[4:0]}) + 10'({4'd0, cdow_month_term(month)})
                  + 10'({3'd0, zk}) + 10'({5'd0, zk[6:2]}) + 10'({5'd0, zj[6:2]})
                  + 10'({1'b0, zj, 2'b00}) + 10'({3'd0, zj});
        state_next = ST_REDUCE;
      end
      ST_REDUCE: begin
        rsp_next.result_day        = day[4:0];
        rsp_next.result_month      = month;
        rsp_next.result_year       = year;
        rsp_next.weekday           = cdow_mod7(wsum);
        rsp_next.year_out_of_range = flag;
        done_next                  = 1'b1;
        state_next                 = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);
  assign rsp  = rsp_reg;

endmodule

[tb/calendar_date_offset_weekday_top_tb.sv]
module calendar_date_offset_weekday_top_tb;
  import cdow_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 24;

  logic clk = 1'b0;
  logic rst;
  logic start;
  req_t req;
  logic busy;
  logic done;
  rsp_t rsp;

  rsp_t expected_dates[$];
  int idle_pct = 0;
  int cycles = 0;
  int mismatches = 0;
  int dates_checked = 0;
  int adds_sent = 0;
  int subs_sent = 0;
  int odd_requests = 0;
  int flagged_dates = 0;

  calendar_date_offset_weekday_top dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .req(req),
    .busy(busy),
    .done(done),
    .rsp(rsp)
  );

  always #5 clk = ~clk;

  function automatic bit is_leap(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int days_in_month(int m, int y);
    if (m == 2) return is_leap(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic rsp_t shift_date(req_t r);
    int day;
    int month;
    int year;
    int count;
    int mz;
    int yz;
    int k;
    int j;
    bit flag;
    rsp_t res;
    day = r.start_day;
    month = r.start_month;
    year = r.start_year;
    count = r.day_count;
    flag = 1'b0;
    if (month < 1) month = 1;
    if (month > 12) month = 12;
    if (year < int'(YEAR_MIN)) begin
      year = YEAR_MIN;
      flag = 1'b1;
    end
    if (year > int'(YEAR_MAX)) begin
      year = YEAR_MAX;
      flag = 1'b1;
    end
    if (day < 1) day = 1;
    if (day > days_in_month(month, year)) day = days_in_month(month, year);
    if (r.req_type == REQ_ADD) begin
      day += count;
      while (day > days_in_month(month, year)) begin
        day -= days_in_month(month, year);
        month++;
        if (month > 12) begin
          month = 1;
          year++;
        end
      end
    end else begin
      while (count >= day) begin
        count -= day;
        month--;
        if (month < 1) begin
          month = 12;
          year--;
        end
        day = days_in_month(month, year);
      end
      day -= count;
    end
    if (year > int'(YEAR_MAX)) begin
      year = YEAR_MAX;
      month = 12;
      day = 31;
      flag = 1'b1;
    end else if (year < int'(YEAR_MIN)) begin
      year = YEAR_MIN;
      month = 1;
      day = 1;
      flag = 1'b1;
    end
    mz = month;
    yz = year;
    if (mz < 3) begin
      mz += 12;
      yz -= 1;
    end
    k = yz % 100;
    j = yz / 100;
    res.result_day = day[4:0];
    res.result_month = month[3:0];
    res.result_year = year[13:0];
    res.weekday = 3'((day + (13 * (mz + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7);
    res.year_out_of_range = flag;
    return res;
  endfunction

  function automatic req_t make_req(logic op, int d, int m, int y, int n);
    req_t r;
    r.req_type = op;
    r.start_day = d[4:0];
    r.start_month = m[3:0];
    r.start_year = y[13:0];
    r.day_count = n[7:0];
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_dates.size());
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (!rst) begin
      if (done) begin
        if (expected_dates.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result %p", $time, rsp);
        end else begin
          exp_rsp = expected_dates.pop_front();
          dates_checked++;
          if (exp_rsp.year_out_of_range) flagged_dates++;
          if (rsp.result_day !== exp_rsp.result_day) begin
            mismatches++;
            $display("%0t: result_day expected %0d actual %0d", $time,
                     exp_rsp.result_day, rsp.result_day);
          end
          if (rsp.result_month !== exp_rsp.result_month) begin
            mismatches++;
            $display("%0t: result_month expected %0d actual %0d", $time,
                     exp_rsp.result_month, rsp.result_month);
          end
          if (rsp.result_year !== exp_rsp.result_year) begin
            mismatches++;
            $display("%0t: result_year expected %0d actual %0d", $time,
                     exp_rsp.result_year, rsp.result_year);
          end
          if (rsp.weekday !== exp_rsp.weekday) begin
            mismatches++;
            $display("%0t: weekday expected %0d actual %0d", $time,
                     exp_rsp.weekday, rsp.weekday);
          end
          if (rsp.year_out_of_range !== exp_rsp.year_out_of_range) begin
            mismatches++;
            $display("%0t: year_out_of_range expected %0b actual %0b", $time,
                     exp_rsp.year_out_of_range, rsp.year_out_of_range);
          end
        end
      end
      if (start && !busy) expected_dates.push_back(shift_date(req));
    end
  end

  task automatic send_request(req_t r);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    if (r.req_type == REQ_ADD) adds_sent++;
    else subs_sent++;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (expected_dates.size() != 0) @(posedge clk);
  endtask

  task automatic test_field_extremes();
    send_request(make_req(REQ_ADD, 0, 0, 0, 0));
    send_request(make_req(REQ_SUB, 31, 15, 16383, 255));
    send_request(make_req(REQ_ADD, 31, 2, 2023, 0));
    send_request(make_req(REQ_SUB, 30, 2, 2024, 0));
    send_request(make_req(REQ_ADD, 31, 4, 1999, 255));
    send_request(make_req(REQ_SUB, 0, 13, 10000, 1));
    send_request(make_req(REQ_ADD, 1, 1, 1, 255));
    send_request(make_req(REQ_SUB, 31, 12, 9999, 255));
    send_request(make_req(REQ_ADD, 15, 14, 8192, 128));
  endtask

  task automatic test_calendar_edges();
    send_request(make_req(REQ_ADD, 31, 12, 9999, 1));
    send_request(make_req(REQ_ADD, 10, 12, 9999, 255));
    send_request(make_req(REQ_SUB, 1, 1, 1, 1));
    send_request(make_req(REQ_SUB, 1, 3, 1, 255));
    send_request(make_req(REQ_ADD, 28, 2, 1900, 1));
    send_request(make_req(REQ_ADD, 28, 2, 2000, 1));
    send_request(make_req(REQ_ADD, 28, 2, 2004, 1));
    send_request(make_req(REQ_SUB, 1, 3, 2100, 1));
    send_request(make_req(REQ_SUB, 1, 3, 2400, 1));
    send_request(make_req(REQ_ADD, 31, 12, 1999, 1));
    send_request(make_req(REQ_SUB, 1, 1, 2000, 1));
    send_request(make_req(REQ_ADD, 14, 10, 1582, 0));
  endtask

  task automatic test_random_traffic(int n, int pct);
    req_t r;
    int y;
    int m;
    idle_pct = pct;
    repeat (n) begin
      case ($urandom_range(9))
        1: y = $urandom_range(3, 1);
        2: y = $urandom_range(9999, 9997);
        default: y = $urandom_range(9999, 1);
      endcase
      m = $urandom_range(12, 1);
      if ($urandom_range(9) != 0) begin
        r = make_req(1'($urandom_range(1)), $urandom_range(days_in_month(m, y), 1), m, y,
                     ($urandom_range(7) == 0) ? 255 : $urandom_range(255));
      end else begin
        r = req_t'($urandom);
        odd_requests++;
      end
      send_request(r);
    end
  endtask

  task automatic test_pause_for_results();
    idle_pct = 0;
    repeat (4) send_request(make_req(1'($urandom_range(1)), $urandom_range(28, 1),
                                     $urandom_range(12, 1), $urandom_range(9999, 1),
                                     $urandom_range(255)));
    hold_until_drained();
    send_request(make_req(REQ_SUB, 29, 2, 2000, 255));
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    req <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_field_extremes();
    test_calendar_edges();
    test_random_traffic(500, 0);
    test_pause_for_results();
    test_random_traffic(500, 54);
    test_random_traffic(480, 30);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d dates: %0d additions, %0d subtractions, %0d raw-field requests,",
             dates_checked, adds_sent, subs_sent, odd_requests);
    $display("%0d results flagged outside years 1..9999, %0d mismatches", flagged_dates,
             mismatches);
    if (mismatches == 0 && expected_dates.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/cdow_pkg.sv
hdl/calendar_date_offset_weekday_top.sv
tb/calendar_date_offset_weekday_top_tb.sv
